FILE: rtl/flos_pkg.sv
// Shared types and constants for the first/last occurrence search block.
// Used by flos_table, flos_ctrl and first_last_occurrence_search.
`default_nettype none

package flos_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int LEN_W      = IDX_W + 1;
    // search pointers: one bit for DEPTH itself, one sign bit for minus one
    localparam int PTR_W      = IDX_W + 2;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_ABSENT = 2'd1,
        ST_EMPTY  = 2'd2
    } status_t;

    typedef struct packed {
        logic                         en;
        logic [IDX_W-1:0]             addr;
        logic signed [DATA_WIDTH-1:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } tbl_rd_t;

endpackage

`default_nettype wire

FILE: rtl/flos_table.sv
// Sorted value table: one write port, one read port with registered data.
// Depends on flos_pkg for depth, width and port structs.
`default_nettype none

module flos_table
    import flos_pkg::*;
(
    input  wire logic                         aclk,
    input  wire tbl_wr_t                      wr,
    input  wire tbl_rd_t                      rd,
    output logic signed [DATA_WIDTH-1:0]      rd_data
);

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];

    // Store a written entry
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read, updated only when the read is enabled
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/flos_ctrl.sv
// Search sequencer: takes input beats, drives table writes and the two
// binary searches, and holds the result beat. Depends on flos_pkg.
`default_nettype none

module flos_ctrl
    import flos_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [LEN_W-1:0]             length_i,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire op_t                          in_op,
    input  wire logic [IDX_W-1:0]             in_index,
    input  wire logic signed [DATA_WIDTH-1:0] in_value,
    output tbl_wr_t                           tbl_wr,
    output tbl_rd_t                           tbl_rd,
    input  wire logic signed [DATA_WIDTH-1:0] tbl_rd_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output status_t                           out_status,
    output logic [IDX_W-1:0]                  out_first,
    output logic [IDX_W-1:0]                  out_last
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOP = 5'b00010,
        S_CMP  = 5'b00100,
        S_CHK  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic signed [PTR_W-1:0]      lo_reg, lo_next;
    logic signed [PTR_W-1:0]      hi_reg, hi_next;
    logic signed [PTR_W-1:0]      mid_reg, mid_next;
    logic                         last_pass_reg, last_pass_next;
    logic signed [DATA_WIDTH-1:0] target_reg, target_next;
    logic                         hit_first_reg, hit_first_next;
    logic [IDX_W-1:0]             first_reg, first_next;
    status_t                      res_status_reg, res_status_next;
    logic [IDX_W-1:0]             res_first_reg, res_first_next;
    logic [IDX_W-1:0]             res_last_reg, res_last_next;
    logic                         out_valid_reg, out_valid_next;
    status_t                      out_status_reg, out_status_next;
    logic [IDX_W-1:0]             out_first_reg, out_first_next;
    logic [IDX_W-1:0]             out_last_reg, out_last_next;

    logic [LEN_W-1:0]             n_sat;
    logic signed [PTR_W-1:0]      hi_init;
    logic signed [PTR_W-1:0]      half;
    logic signed [PTR_W-1:0]      mid;
    logic                         in_fire;
    logic                         hit;

    // Clamp the entry count to the table depth
    assign n_sat   = (length_i > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : length_i;
    assign hi_init = $signed({1'b0, n_sat}) - $signed(PTR_W'(1));

    // Probe point: lower middle for the first search, upper for the last
    assign half = (hi_reg - lo_reg) >>> 1;
    assign mid  = last_pass_reg ? (lo_reg + half + $signed(PTR_W'(1))) : (lo_reg + half);

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign hit      = (tbl_rd_data == target_reg);

    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        last_pass_next  = last_pass_reg;
        target_next     = target_reg;
        hit_first_next  = hit_first_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        tbl_wr.en       = 1'b0;
        tbl_wr.addr     = in_index;
        tbl_wr.data     = in_value;
        tbl_rd.en       = 1'b0;
        tbl_rd.addr     = mid[IDX_W-1:0];

        // Drop the result beat once taken
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (in_op == OP_WRITE) begin
                        tbl_wr.en = 1'b1;
                    end else if (n_sat == '0) begin
                        res_status_next = ST_EMPTY;
                        res_first_next  = '0;
                        res_last_next   = '0;
                        state_next      = S_DONE;
                    end else begin
                        target_next    = in_value;
                        lo_next        = '0;
                        hi_next        = hi_init;
                        last_pass_next = 1'b0;
                        state_next     = S_LOOP;
                    end
                end
            end
            S_LOOP: begin
                tbl_rd.en = 1'b1;
                if (lo_reg < hi_reg) begin
                    mid_next   = mid;
                    state_next = S_CMP;
                end else begin
                    // Search done: read the landing entry for the hit check
                    tbl_rd.addr = last_pass_reg ? hi_reg[IDX_W-1:0] : lo_reg[IDX_W-1:0];
                    state_next  = S_CHK;
                end
            end
            S_CMP: begin
                if (tbl_rd_data > target_reg) begin
                    hi_next = mid_reg - $signed(PTR_W'(1));
                end else if (tbl_rd_data < target_reg) begin
                    lo_next = mid_reg + $signed(PTR_W'(1));
                end else if (last_pass_reg) begin
                    lo_next = mid_reg;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = S_LOOP;
            end
            S_CHK: begin
                if (!last_pass_reg) begin
                    // Keep the first search outcome, restart for the last
                    hit_first_next = hit;
                    first_next     = lo_reg[IDX_W-1:0];
                    lo_next        = '0;
                    hi_next        = hi_init;
                    last_pass_next = 1'b1;
                    state_next     = S_LOOP;
                end else begin
                    if (hit_first_reg && hit) begin
                        res_status_next = ST_FOUND;
                        res_first_next  = first_reg;
                        res_last_next   = hi_reg[IDX_W-1:0];
                    end else begin
                        res_status_next = ST_ABSENT;
                        res_first_next  = '0;
                        res_last_next   = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // Load the output register when it is free or being drained
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_first_next  = res_first_reg;
                    out_last_next   = res_last_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Search pointers and payload
    always_ff @(posedge aclk) begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        last_pass_reg  <= last_pass_next;
        target_reg     <= target_next;
        hit_first_reg  <= hit_first_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_last_reg   <= res_last_next;
        out_status_reg <= out_status_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_first  = out_first_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/first_last_occurrence_search.sv
// First/last occurrence search over a sorted table of signed entries.
// Write beats are stored in the table when accepted. A query makes two binary
// searches, each with at most ceil(log2(length)) probes plus one check read;
// each probe is a table read followed by a compare.
// One item is in work at a time; a finished result waits in an output register.
// Reset (aresetn, synchronous, active low) clears length and control; the table is not cleared.
`default_nettype none

module first_last_occurrence_search
    import flos_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // length register write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [10:0]  cfg_data,
    // input beats
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,   // [9:0] index, [41:10] value, rest zero
    input  wire logic         s_axis_tuser,   // [0] op
    // result beats
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [9:0] first_index, [19:10] last_index
    output logic [1:0]        m_axis_tuser    // [1:0] status
);

    logic [LEN_W-1:0]             length_reg;
    tbl_wr_t                      tbl_wr;
    tbl_rd_t                      tbl_rd;
    logic signed [DATA_WIDTH-1:0] tbl_rd_data;
    status_t                      out_status;
    logic [IDX_W-1:0]             out_first;
    logic [IDX_W-1:0]             out_last;

    // Length register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= '0;
        end else if (cfg_valid) begin
            length_reg <= cfg_data;
        end
    end

    flos_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .length_i    (length_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (op_t'(s_axis_tuser)),
        .in_index    (s_axis_tdata[9:0]),
        .in_value    ($signed(s_axis_tdata[41:10])),
        .tbl_wr      (tbl_wr),
        .tbl_rd      (tbl_rd),
        .tbl_rd_data (tbl_rd_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (out_status),
        .out_first   (out_first),
        .out_last    (out_last)
    );

    flos_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (tbl_rd_data)
    );

    // Pack the result beat
    assign m_axis_tdata = {4'b0, out_last, out_first};
    assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

FILE: test/first_last_occurrence_search_test.sv
// Self-checking testbench for first_last_occurrence_search: loads sorted tables,
// queries them with bursty input and stalled output, checks against a local predictor.
// Depends on flos_pkg and the first_last_occurrence_search RTL.
`default_nettype none

module first_last_occurrence_search_test;
    import flos_pkg::*;

    // the full-table load and the directed beats add about a thousand more
    localparam int          RANDOM_ITEMS  = 450;
    localparam int          SETTLE_CYCLES = 64;
    localparam int unsigned RUN_LIMIT     = 1000000;
    localparam int          LEN_MAX       = (1 << LEN_W) - 1;

    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        op_t                          op;
        logic [IDX_W-1:0]             index;
        logic signed [DATA_WIDTH-1:0] value;
    } table_item_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] last_idx;
    } bounds_t;

    logic              aclk;
    logic              aresetn       = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic [LEN_W-1:0]  cfg_data      = '0;
    logic              s_axis_tvalid = 1'b0;
    logic [47:0]       s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tready = 1'b0;
    wire logic         cfg_ready;
    wire logic         s_axis_tready;
    wire logic         m_axis_tvalid;
    wire logic [23:0]  m_axis_tdata;
    wire logic [1:0]   m_axis_tuser;

    // table as the stimulus plans it (ahead of the block) and as accepted beats leave it
    logic signed [DATA_WIDTH-1:0] staged_table [DEPTH];
    logic signed [DATA_WIDTH-1:0] loaded_table [DEPTH];
    logic [LEN_W-1:0]             loaded_length = '0;

    table_item_t pending_beats [$];
    bounds_t     awaited_bounds [$];
    table_item_t beat_on_bus;
    bounds_t     oldest_bounds;

    int          items_queued  = 0;
    int          items_done    = 0;
    int          results_seen  = 0;
    int          mismatches    = 0;
    int          burst_left    = 1;
    int          idle_left     = 0;
    int          stall_span    = 0;
    logic [15:0] stall_mask    = 16'hFFFF;
    int unsigned cycles        = 0;

    first_last_occurrence_search dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [9:0] index, [41:10] value, rest zero
        .s_axis_tuser  (s_axis_tuser),   // [0] op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [9:0] first_index, [19:10] last_index
        .m_axis_tuser  (m_axis_tuser)    // [1:0] status
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Left-biased then right-biased binary search over the active prefix;
    // found only when both land on the target.
    function automatic bounds_t predict_bounds(logic signed [DATA_WIDTH-1:0] target);
        bounds_t r;
        int      active, lo, hi, mid, first_at;
        logic    first_hit;
        r.status    = ST_EMPTY;
        r.first_idx = '0;
        r.last_idx  = '0;
        active = (loaded_length > DEPTH) ? DEPTH : int'(loaded_length);
        if (active == 0)
            return r;
        lo = 0;
        hi = active - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (loaded_table[mid] > target)
                hi = mid - 1;
            else if (loaded_table[mid] < target)
                lo = mid + 1;
            else
                hi = mid;
        end
        first_at  = lo;
        first_hit = (loaded_table[lo] == target);
        lo = 0;
        hi = active - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2 + 1;
            if (loaded_table[mid] > target)
                hi = mid - 1;
            else if (loaded_table[mid] < target)
                lo = mid + 1;
            else
                lo = mid;
        end
        if (first_hit && loaded_table[hi] == target) begin
            r.status    = ST_FOUND;
            r.first_idx = first_at[IDX_W-1:0];
            r.last_idx  = hi[IDX_W-1:0];
        end else begin
            r.status = ST_ABSENT;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        // keep the log short when everything breaks
        if (mismatches <= 40)
            $display("mismatch at result beat %0d: %s", results_seen, what);
    endtask

    task automatic queue_beat(input op_t op, input logic [IDX_W-1:0] idx,
                              input logic signed [DATA_WIDTH-1:0] val);
        table_item_t it;
        it.op    = op;
        it.index = idx;
        it.value = val;
        pending_beats.push_back(it);
        items_queued++;
        if (op == OP_WRITE)
            staged_table[idx] = val;
    endtask

    // Hold until every queued beat is taken and every result is back, then let
    // the block drain any write still in flight.
    task automatic wait_idle;
        while (items_done != items_queued || awaited_bounds.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        wait_idle();
        cfg_data  <= len;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid     <= 1'b0;
        loaded_length  = len;
    endtask

    // Driver: bursts of beats with random gaps; track accepted writes, predict on every accepted query.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (beat_on_bus.op == OP_WRITE)
                    loaded_table[beat_on_bus.index] = beat_on_bus.value;
                else
                    awaited_bounds.push_back(predict_bounds(beat_on_bus.value));
                items_done++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (idle_left != 0 || pending_beats.size() == 0) begin
                    if (idle_left != 0)
                        idle_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    beat_on_bus    = pending_beats.pop_front();
                    s_axis_tdata  <= {6'b0, beat_on_bus.value, beat_on_bus.index};
                    s_axis_tuser  <= beat_on_bus.op;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        case ($urandom_range(0, 5))
                            0, 1:    idle_left = 0;
                            2, 3, 4: idle_left = $urandom_range(1, 6);
                            default: idle_left = $urandom_range(10, 30);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: rotate a stall mask, swap in a new one every so often.
    always @(posedge aclk) begin
        if (stall_span == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_mask <= 16'hFFFF;
                1:       stall_mask <= ~(16'h1 << $urandom_range(0, 15));
                2:       stall_mask <= 16'h0001 | (16'h1 << $urandom_range(0, 15));
                default: stall_mask <= 16'($urandom) | 16'h0001;
            endcase
            stall_span <= $urandom_range(16, 200);
        end else begin
            stall_mask <= {stall_mask[0], stall_mask[15:1]};
            stall_span <= stall_span - 1;
        end
        m_axis_tready <= stall_mask[0];
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (awaited_bounds.size() == 0) begin
                report_mismatch("result beat with no query pending");
            end else begin
                oldest_bounds = awaited_bounds.pop_front();
                if (m_axis_tuser !== oldest_bounds.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tuser, oldest_bounds.status));
                if (m_axis_tdata[9:0] !== oldest_bounds.first_idx)
                    report_mismatch($sformatf("first_index %0d, expected %0d",
                                              m_axis_tdata[9:0], oldest_bounds.first_idx));
                if (m_axis_tdata[19:10] !== oldest_bounds.last_idx)
                    report_mismatch($sformatf("last_index %0d, expected %0d",
                                              m_axis_tdata[19:10], oldest_bounds.last_idx));
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        longint                       v, lo, hi, stride;
        int                           len, n, k, mark, idx;
        logic signed [DATA_WIDTH-1:0] target, held;
        table_item_t                  undo;
        table_item_t                  undo_log [$];

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: queries only, nothing has been written yet
        set_length(LEN_W'(0));
        queue_beat(OP_QUERY, 10'h3FF, VAL_MIN);
        queue_beat(OP_QUERY, 10'h000, VAL_MAX);

        // load every entry in order, with runs of both extremes at the ends
        v = longint'(VAL_MIN);
        for (int i = 0; i < DEPTH; i++) begin
            if (i < 3) begin
                v = longint'(VAL_MIN);
            end else if (i >= DEPTH - 3) begin
                v = longint'(VAL_MAX);
            end else begin
                case ($urandom_range(0, 3))
                    0:       ;
                    1:       v = v + $urandom_range(1, 3);
                    default: v = v + $urandom_range(0, 12000000);
                endcase
                if (v > longint'(VAL_MAX))
                    v = longint'(VAL_MAX);
            end
            queue_beat(OP_WRITE, IDX_W'(i), 32'(v));
        end

        // one entry, then two
        set_length(LEN_W'(1));
        queue_beat(OP_QUERY, IDX_W'($urandom_range(0, DEPTH - 1)), VAL_MIN);
        queue_beat(OP_QUERY, IDX_W'($urandom_range(0, DEPTH - 1)), VAL_MAX);
        set_length(LEN_W'(2));
        queue_beat(OP_QUERY, IDX_W'($urandom_range(0, DEPTH - 1)), VAL_MIN);

        // full table
        set_length(LEN_W'(DEPTH));
        queue_beat(OP_QUERY, 10'h155, VAL_MIN);
        queue_beat(OP_QUERY, 10'h2AA, VAL_MAX);
        queue_beat(OP_QUERY, 10'h0, staged_table[511]);
        queue_beat(OP_QUERY, 10'h0, staged_table[511] + 32'sd1);
        queue_beat(OP_QUERY, 10'h0, 32'sd0);

        // length above the table depth saturates
        set_length(LEN_W'(LEN_MAX));
        queue_beat(OP_QUERY, 10'h3FF, VAL_MAX);
        queue_beat(OP_QUERY, 10'h3FF, staged_table[1000]);
        queue_beat(OP_QUERY, 10'h3FF, VAL_MIN + 32'sd1);

        // out-of-order entry in the middle, then put the old value back
        held = staged_table[512];
        queue_beat(OP_WRITE, IDX_W'(512), VAL_MIN);
        queue_beat(OP_QUERY, 10'h0, VAL_MIN);
        queue_beat(OP_QUERY, 10'h0, held);
        queue_beat(OP_WRITE, IDX_W'(512), held);
        set_length(LEN_W'(DEPTH + 1));
        queue_beat(OP_QUERY, 10'h0, staged_table[700]);

        // random phases: mostly short sorted prefixes, now and then the whole table
        mark = items_queued;
        while (items_queued - mark < RANDOM_ITEMS) begin
            k = $urandom_range(0, 15);
            if (k == 0)
                len = DEPTH;
            else if (k == 1)
                len = ($urandom_range(0, 3) == 0) ? LEN_MAX : $urandom_range(DEPTH + 1, LEN_MAX);
            else if (k == 2)
                len = $urandom_range(65, DEPTH - 1);
            else if (k == 3)
                len = 0;
            else if (k < 6)
                len = k - 3;
            else
                len = $urandom_range(3, 64);
            set_length(LEN_W'(len));
            n = (len > DEPTH) ? DEPTH : len;

            // rewrite the prefix sorted and bounded by the entry above it,
            // so the whole table stays in order
            if (n > 0 && n <= 64 && $urandom_range(0, 3) != 0) begin
                hi = longint'(staged_table[n]);
                case ($urandom_range(0, 3))
                    0:       lo = longint'(VAL_MIN);
                    1:       lo = hi - $urandom_range(0, 4 * n);
                    default: lo = longint'(VAL_MIN)
                                  + (longint'($urandom) % (hi - longint'(VAL_MIN) + 1));
                endcase
                if (lo < longint'(VAL_MIN))
                    lo = longint'(VAL_MIN);
                stride = (hi - lo) / n * 2;
                if (stride > 64'h7FFF_FFFF)
                    stride = 64'h7FFF_FFFF;
                v = lo;
                for (int i = 0; i < n; i++) begin
                    queue_beat(OP_WRITE, IDX_W'(i), 32'(v));
                    case ($urandom_range(0, 2))
                        0:       ;
                        1:       v = v + $urandom_range(1, 2);
                        default: v = v + $urandom_range(0, 32'(stride));
                    endcase
                    if (v > hi)
                        v = hi;
                end
            end

            repeat ($urandom_range(6, 24)) begin
                // stray write, undone at the end of the phase
                if ($urandom_range(0, 9) == 0) begin
                    idx         = $urandom_range(0, DEPTH - 1);
                    undo.op     = OP_WRITE;
                    undo.index  = IDX_W'(idx);
                    undo.value  = staged_table[idx];
                    undo_log.push_back(undo);
                    queue_beat(OP_WRITE, IDX_W'(idx), $urandom);
                end
                k = $urandom_range(0, 19);
                if (n != 0 && k < 10)
                    target = staged_table[$urandom_range(0, n - 1)];
                else if (n != 0 && k < 14)
                    target = staged_table[$urandom_range(0, n - 1)]
                             + (k[0] ? 32'sd1 : -32'sd1);
                else if (k < 16)
                    target = k[0] ? VAL_MAX : VAL_MIN;
                else
                    target = $urandom;
                queue_beat(OP_QUERY, IDX_W'($urandom_range(0, DEPTH - 1)), target);
            end
            while (undo_log.size() != 0) begin
                undo = undo_log.pop_back();
                queue_beat(OP_WRITE, undo.index, undo.value);
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: first_last_occurrence_search.f
rtl/flos_pkg.sv
rtl/flos_table.sv
rtl/flos_ctrl.sv
rtl/first_last_occurrence_search.sv
test/first_last_occurrence_search_test.sv
